[rtl/core/afr_pkg.sv]
// Package for the API frame receiver: framing constants, result kinds and
// the result record passed from the parser to the output register.
// No dependencies.
package afr_pkg;

  // Frame format constants.
  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] SUM_GOOD    = 8'hFF;

  // Largest payload length the receiver accepts (1 to 64).
  localparam int MAX_PAYLOAD = 64;
  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

  // Width of the payload byte counter, enough for indexes below MAX_PAYLOAD.
  localparam int IDX_W = (MAX_PAYLOAD > 2) ? $clog2(MAX_PAYLOAD) : 1;

  // Reset value of the hunt limit register.
  localparam logic [7:0] HUNT_LIMIT_RST = 8'd5;

  // Register word indexes on the configuration port.
  localparam logic REG_HUNT_LIMIT = 1'b0;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_NODELIM = 3'd3,
    KIND_TOOLONG = 3'd4
  } kind_t;

  // One result record.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [5:0]  position;
    logic [7:0]  frame_length;
  } result_t;

endpackage

[rtl/core/afr_cfg.sv]
// Configuration register file of the API frame receiver (APB-style port).
// Depends on afr_pkg.
module afr_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  hunt_limit
);
  import afr_pkg::*;

  logic wr_en;

  // A write completes in the access cycle; the port never stalls.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HUNT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_limit <= HUNT_LIMIT_RST;
    end else if (wr_en) begin
      hunt_limit <= pwdata[7:0];
    end
  end

  // Read data: the register value, zero beyond the register list.
  always_comb begin
    if (paddr[2] == REG_HUNT_LIMIT) begin
      prdata = {24'd0, hunt_limit};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

[rtl/core/afr_parser.sv]
// Frame parser of the API frame receiver: phase state machine, delimiter
// hunt, length capture, payload indexing and checksum. Depends on afr_pkg.
module afr_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      hunt_limit,
  output logic            res_valid,
  output afr_pkg::result_t res
);
  import afr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  phase_t           phase, phase_next;
  logic [7:0]       miss_count, miss_count_next;
  logic [7:0]       payload_length, payload_length_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       sum_add;
  logic [8:0]       idx_inc;

  assign sum_add = running_sum + rx_byte;
  assign idx_inc = 9'(byte_index) + 9'd1;

  // Next state and result for the byte in hand.
  always_comb begin
    phase_next          = phase;
    miss_count_next     = miss_count;
    payload_length_next = payload_length;
    byte_index_next     = byte_index;
    running_sum_next    = running_sum;
    res_valid           = 1'b0;
    res                 = '{kind: KIND_DATA, data: 8'd0, position: 6'd0,
                            frame_length: 8'd0};
    unique case (phase)
      PH_LEN_HI: begin
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = rx_byte;
        byte_index_next     = '0;
        running_sum_next    = 8'd0;
        if (rx_byte > MAX_PAYLOAD_B) begin
          phase_next       = PH_HUNT;
          miss_count_next  = 8'd0;
          res_valid        = 1'b1;
          res.kind         = KIND_TOOLONG;
          res.frame_length = rx_byte;
        end else if (rx_byte == 8'd0) begin
          phase_next = PH_CHECK;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_DATA;
        res.data         = rx_byte;
        res.position     = 6'(byte_index);
        res.frame_length = payload_length;
        running_sum_next = sum_add;
        if (idx_inc >= {1'b0, payload_length}) begin
          byte_index_next = '0;
          phase_next      = PH_CHECK;
        end else begin
          byte_index_next = idx_inc[IDX_W-1:0];
        end
      end
      PH_CHECK: begin
        running_sum_next = sum_add;
        res_valid        = 1'b1;
        res.kind         = (sum_add == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM;
        res.frame_length = payload_length;
        phase_next       = PH_HUNT;
        miss_count_next  = 8'd0;
      end
      default: begin
        // Hunting, and any unused phase code.
        phase_next = PH_HUNT;
        if (rx_byte == START_DELIM) begin
          miss_count_next = 8'd0;
          phase_next      = PH_LEN_HI;
        end else if (miss_count >= hunt_limit) begin
          miss_count_next = 8'd0;
          res_valid       = 1'b1;
          res.kind        = KIND_NODELIM;
        end else begin
          miss_count_next = miss_count + 8'd1;
        end
      end
    endcase
  end

  // State registers advance on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      miss_count     <= 8'd0;
      payload_length <= 8'd0;
      byte_index     <= '0;
      running_sum    <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      miss_count     <= miss_count_next;
      payload_length <= payload_length_next;
      byte_index     <= byte_index_next;
      running_sum    <= running_sum_next;
    end
  end

endmodule

[rtl/core/afr_out_reg.sv]
// Result register of the API frame receiver: holds one result until the
// downstream side takes it. Depends on afr_pkg.
module afr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  afr_pkg::result_t res_in,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output afr_pkg::result_t res_out
);
  import afr_pkg::*;

  // The register can take a new result when empty or emptying this cycle.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (free && load) begin
      res_out <= res_in;
    end
  end

endmodule

[rtl/core/api_frame_receiver.sv]
// API frame receiver: one byte is taken per cycle while the result register
// is free, and yields at most one result, registered there. Depends on
// afr_pkg, afr_cfg, afr_parser and afr_out_reg.
//
// Takes one byte per clock cycle, back to back, and loads its result, if any,
// into the result register. A byte is refused only while the result register
// holds a result that the downstream side has not taken; bytes that produce
// no result (delimiter, length high byte, tolerated noise) still wait for
// that register to free up. Results are payload bytes with their position,
// frame good, bad checksum, missing start delimiter after hunt_limit
// discarded bytes, and a declared length above MAX_PAYLOAD.
module api_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // Received byte channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data,
  output logic [5:0]  position,
  output logic [7:0]  frame_length,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import afr_pkg::*;

  logic [7:0] hunt_limit;
  logic       step;
  logic       res_valid;
  logic       free;
  result_t    res;
  result_t    res_q;

  afr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .hunt_limit(hunt_limit)
  );

  // A byte transfer happens when the result register can take its result.
  assign in_ready = free;
  assign step     = in_valid && in_ready;

  afr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (rx_byte),
    .hunt_limit(hunt_limit),
    .res_valid (res_valid),
    .res       (res)
  );

  afr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && res_valid),
    .res_in   (res),
    .free     (free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_out  (res_q)
  );

  assign kind         = res_q.kind;
  assign data         = res_q.data;
  assign position     = res_q.position;
  assign frame_length = res_q.frame_length;

  // Only payload results carry data and a position.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_DATA) |-> (data == 8'd0) && (position == 6'd0))
    else $error("non-payload result carries data or position");

  // A no-delimiter report carries no frame length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NODELIM) |-> (frame_length == 8'd0))
    else $error("no-delimiter result carries a frame length");

  // Payload bytes carry a nonzero frame length no larger than MAX_PAYLOAD.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DATA) |->
      (frame_length != 8'd0) && (frame_length <= MAX_PAYLOAD_B))
    else $error("payload byte outside an accepted frame length");

  // An empty result register never holds off the input.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused while the result register is empty");

endmodule
